>>> sv/rkg_pkg.sv
package rkg_pkg;

   localparam int unsigned NumWords = 8;

   typedef logic [31:0] word_type;
   typedef word_type [NumWords-1:0] word_array_type;

   // counter increments a0..a7
   localparam word_type RKG_A [NumWords] = '{
      32'h4D34D34D, 32'hD34D34D3, 32'h34D34D34, 32'h4D34D34D,
      32'hD34D34D3, 32'h34D34D34, 32'h4D34D34D, 32'hD34D34D3
   };

   // one pulse per datapath action, driven by the controller
   typedef struct packed {
      logic capture;
      logic load_key;
      logic cnt_step;
      logic add_step;
      logic sq_step;
      logic mix_step;
      logic modify_step;
      logic load_out;
   } cmd_type;

endpackage

>>> sv/rkg_datapath.sv
module rkg_datapath (
   input  logic             clock,
   input  logic             reset,
   input  logic [63:0]      key_low,
   input  logic [63:0]      key_high,
   input  rkg_pkg::cmd_type cmd,
   input  logic [127:0]     req_data,
   output logic [127:0]     rsp_data
);
   import rkg_pkg::*;

   word_array_type x_ff, x_in;
   word_array_type c_ff, c_in;
   logic           carry_ff, carry_in;
   word_array_type u_ff;
   logic [NumWords-1:0][63:0] sq_ff;
   word_array_type g;
   logic [127:0]   data_ff;
   logic [127:0]   rsp_ff;
   logic [127:0]   key;
   logic [63:0]    s_low, s_high;

   function automatic logic [15:0] subkey(input logic [127:0] k, input int i);
      return k[16*(i & 7) +: 16];
   endfunction

   function automatic word_type rotl16(input word_type v);
      return {v[15:0], v[31:16]};
   endfunction

   function automatic word_type rotl8(input word_type v);
      return {v[23:0], v[31:24]};
   endfunction

   assign key = {key_high, key_low};

   always_comb begin
      for (int j = 0; j < NumWords; j++) begin
         g[j] = sq_ff[j][31:0] ^ sq_ff[j][63:32];
      end
   end

   always_comb begin
      logic        cy;
      logic [32:0] t;
      x_in     = x_ff;
      c_in     = c_ff;
      carry_in = carry_ff;
      cy       = carry_ff;
      t        = '0;
      if (cmd.load_key) begin
         for (int j = 0; j < NumWords; j++) begin
            if ((j & 1) != 0) begin
               x_in[j] = {subkey(key, j + 5), subkey(key, j + 4)};
               c_in[j] = {subkey(key, j), subkey(key, j + 1)};
            end else begin
               x_in[j] = {subkey(key, j + 1), subkey(key, j)};
               c_in[j] = {subkey(key, j + 4), subkey(key, j + 5)};
            end
         end
         carry_in = 1'b0;
      end else if (cmd.cnt_step) begin
         // counter chain, carry ripples from word 0 up to word 7
         for (int j = 0; j < NumWords; j++) begin
            t       = {1'b0, c_ff[j]} + {1'b0, RKG_A[j]} + {32'd0, cy};
            c_in[j] = t[31:0];
            cy      = t[32];
         end
         carry_in = cy;
      end else if (cmd.mix_step) begin
         x_in[0] = g[0] + rotl16(g[7]) + rotl16(g[6]);
         x_in[1] = g[1] + rotl8(g[0])  + g[7];
         x_in[2] = g[2] + rotl16(g[1]) + rotl16(g[0]);
         x_in[3] = g[3] + rotl8(g[2])  + g[1];
         x_in[4] = g[4] + rotl16(g[3]) + rotl16(g[2]);
         x_in[5] = g[5] + rotl8(g[4])  + g[3];
         x_in[6] = g[6] + rotl16(g[5]) + rotl16(g[4]);
         x_in[7] = g[7] + rotl8(g[6])  + g[5];
      end else if (cmd.modify_step) begin
         for (int j = 0; j < NumWords; j++) begin
            c_in[j] = c_ff[j] ^ x_ff[3'(j + 4)];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff     <= '0;
         c_ff     <= '0;
         carry_ff <= 1'b0;
      end else begin
         x_ff     <= x_in;
         c_ff     <= c_in;
         carry_ff <= carry_in;
      end
   end

   // g-function operands and squares, one register stage each
   always_ff @(posedge clock) begin
      for (int j = 0; j < NumWords; j++) begin
         if (cmd.add_step) begin
            u_ff[j] <= x_ff[j] + c_ff[j];
         end
         if (cmd.sq_step) begin
            sq_ff[j] <= {32'd0, u_ff[j]} * {32'd0, u_ff[j]};
         end
      end
   end

   assign s_low  = {x_ff[2][31:16] ^ x_ff[5][15:0], x_ff[2][15:0] ^ x_ff[7][31:16],
                    x_ff[0][31:16] ^ x_ff[3][15:0], x_ff[0][15:0] ^ x_ff[5][31:16]};
   assign s_high = {x_ff[6][31:16] ^ x_ff[1][15:0], x_ff[6][15:0] ^ x_ff[3][31:16],
                    x_ff[4][31:16] ^ x_ff[7][15:0], x_ff[4][15:0] ^ x_ff[1][31:16]};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         data_ff <= req_data;
      end
      if (cmd.load_out) begin
         rsp_ff <= data_ff ^ {s_high, s_low};
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> sv/rkg_controller.sv
module rkg_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_restart,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output rkg_pkg::cmd_type cmd
);
   import rkg_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_CNT    = 3'd2;
   localparam logic [2:0] ST_ADDU   = 3'd3;
   localparam logic [2:0] ST_SQR    = 3'd4;
   localparam logic [2:0] ST_MIX    = 3'd5;
   localparam logic [2:0] ST_MODIFY = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] iter_ff, iter_in;
   logic       setup_ff, setup_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      setup_in = setup_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               setup_in    = req_restart;
               state_in    = req_restart ? ST_LOAD : ST_CNT;
            end
         end
         ST_LOAD: begin
            cmd.load_key = 1'b1;
            iter_in      = '0;
            state_in     = ST_CNT;
         end
         ST_CNT: begin
            cmd.cnt_step = 1'b1;
            state_in     = ST_ADDU;
         end
         ST_ADDU: begin
            cmd.add_step = 1'b1;
            state_in     = ST_SQR;
         end
         ST_SQR: begin
            cmd.sq_step = 1'b1;
            state_in    = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix_step = 1'b1;
            if (!setup_ff) begin
               state_in = ST_DONE;
            end else if (iter_ff == 2'd3) begin
               setup_in = 1'b0;
               state_in = ST_MODIFY;
            end else begin
               iter_in  = iter_ff + 2'd1;
               state_in = ST_CNT;
            end
         end
         ST_MODIFY: begin
            cmd.modify_step = 1'b1;
            state_in        = ST_CNT;
         end
         ST_DONE: begin
            if (!valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
         setup_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         setup_ff <= setup_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   a_restart_loads: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_restart |=> state_ff == ST_LOAD)
      else $error("restart item did not enter key load");

   a_plain_counts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_restart |=> state_ff == ST_CNT && !setup_ff)
      else $error("plain item did not go straight to the counter step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !valid_ff || rsp_tready)
      else $error("result register overwritten while an item waits");

   a_modify_after_four: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MODIFY |-> $past(iter_ff) == 2'd3 && !setup_ff)
      else $error("counter modification not after the fourth setup iteration");

endmodule

>>> sv/rabbit_keystream_generator.sv
// channel  | direction | handshake              | payload
// req      | in        | req_tvalid/req_tready  | tuser: restart, tdata: data_low, data_high
// rsp      | out       | rsp_tvalid/rsp_tready  | tdata: out_low, out_high
// csr      | in        | psel/penable, pready=1 | key_low at 0x0, key_high at 0x8, 64 bits
//
// an item without restart runs one iteration before rsp_tvalid rises, and the
// next item is taken after the result register is loaded: one iteration is
// counter step, operand add, eight parallel squarers, mix, then the result
// register is loaded; a restart item runs key load, four setup iterations,
// counter modification and the generating iteration before rsp_tvalid rises
// one item is worked on at a time; the next is taken while a result still waits
// reset clears cipher state, counters, carry and keys; rsp_tready low holds the
// result register and the controller waits before overwriting it
module rabbit_keystream_generator (
   input  logic         clock,
   input  logic         reset,
   // slave side
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,   // restart
   input  logic [127:0] req_tdata,   // data_low [63:0], data_high [127:64]
   // master side
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // out_low [63:0], out_high [127:64]
   // register port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);
   import rkg_pkg::*;

   logic [63:0] key_low_ff, key_high_ff;
   cmd_type     cmd;
   logic        csr_write;

   // registers are 64 bits on an 8-byte pitch, paddr bit 3 picks the word
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_write) begin
         if (csr_paddr[3]) begin
            key_high_ff <= csr_pwdata;
         end else begin
            key_low_ff <= csr_pwdata;
         end
      end
   end

   assign csr_prdata = csr_paddr[3] ? key_high_ff : key_low_ff;

   // sequencer: walks key load, iterations and result hand-off
   rkg_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_restart (req_tuser),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .cmd         (cmd)
   );

   // cipher state, counters, squarers and the output register
   rkg_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .key_low  (key_low_ff),
      .key_high (key_high_ff),
      .cmd      (cmd),
      .req_data (req_tdata),
      .rsp_data (rsp_tdata)
   );

endmodule
